/* hdl/bru_pkg.sv */
// Shared types and constants for the 24-bit BMP pixel unpacker.
// No dependencies; imported by every module of the block.
`default_nettype none
package bru_pkg;

    localparam int DIM_W = 13;
    localparam int COORD_W = 12;
    localparam int HCNT_W = 6;

    localparam logic [DIM_W-1:0]  MAX_DIM  = 13'd4096;
    localparam logic [DIM_W-1:0]  SIZE_SAT = 13'h1FFF;
    localparam logic [7:0]        ALPHA    = 8'hFF;
    localparam logic [7:0]        CHAR_B   = 8'h42;
    localparam logic [7:0]        CHAR_M   = 8'h4D;

    localparam logic [HCNT_W-1:0] WIDTH_LO  = 6'd18;
    localparam logic [HCNT_W-1:0] WIDTH_HI  = 6'd21;
    localparam logic [HCNT_W-1:0] HEIGHT_LO = 6'd22;
    localparam logic [HCNT_W-1:0] HEIGHT_HI = 6'd25;
    localparam logic [HCNT_W-1:0] HDR_LAST  = 6'd53;
    localparam logic [HCNT_W-1:0] SIG_B_POS = 6'd0;
    localparam logic [HCNT_W-1:0] SIG_M_POS = 6'd1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_PAD    = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first;
    } item_t;

    typedef struct packed {
        logic [31:0]        pixel_word;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last;
        logic               error;
    } result_t;

endpackage
`default_nettype wire

/* hdl/bmp_rgb24_pixel_unpacker_top.sv */
// Top level of the 24-bit BMP pixel unpacker: stream ports and packing.
// Depends on bru_pkg, bru_in_stage and bru_parser.
//
// Feed the bytes of an uncompressed 24-bit bottom-up BMP file one word at a
// time, with s_tuser set on the first byte of each file. The 54-byte header is
// checked for the BM signature and a width and height from 1 to 4096; pixel
// data is taken to start at byte 54. Every third data byte yields one word:
// 0xFF alpha over the three color bytes in arrival order, with its column and
// row (rows count down from height-1), m_tlast on the final pixel. Row padding
// is skipped. A bad file gives a single word with m_tuser set and all other
// fields zero, and input is then dropped until the next s_tuser byte. One byte
// is accepted every cycle unless m_tready holds back a result word; the rate
// is set by the parser state update between the input and result registers,
// and a result word is offered in the cycle after its last byte is taken.
`default_nettype none
module bmp_rgb24_pixel_unpacker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // file_byte[7:0]
    input  wire logic [0:0]  s_tuser,   // first[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // pixel_word[31:0], column[43:32], row[55:44]
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // error[0]
);
    import bru_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t res;

    assign in_item.file_byte = s_tdata;
    assign in_item.first     = s_tuser[0];

    bru_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    bru_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = {res.row, res.column, res.pixel_word};
    assign m_tlast = res.last;
    assign m_tuser = res.error;

endmodule
`default_nettype wire

/* hdl/bru_in_stage.sv */
// Input register stage of the BMP pixel unpacker.
// Holds one incoming word for the parser; depends on bru_pkg.
`default_nettype none
module bru_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bru_pkg::item_t in_item,
    output logic                item_valid,
    output bru_pkg::item_t      item,
    input  wire logic           item_take
);
    import bru_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/bru_parser.sv */
// Header parser, pixel grouping and result register of the BMP unpacker.
// Depends on bru_pkg; fed by bru_in_stage.
`default_nettype none
module bru_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           item_valid,
    input  wire bru_pkg::item_t item,
    output logic                item_take,
    output logic                res_valid,
    output bru_pkg::result_t    res,
    input  wire logic           res_ready
);
    import bru_pkg::*;

    phase_t              phase_reg, phase_next, phase_cur;
    logic [HCNT_W-1:0]   hcount_reg, hcount_next, hcount_cur;
    logic [DIM_W-1:0]    width_reg, width_next, width_cur;
    logic [DIM_W-1:0]    height_reg, height_next, height_cur;
    logic [COORD_W-1:0]  column_reg, column_next, column_cur;
    logic [COORD_W-1:0]  row_reg, row_next, row_cur;
    logic [1:0]          bip_reg, bip_next, bip_cur;
    logic [15:0]         held_reg, held_next, held_cur;
    logic [1:0]          pad_reg, pad_next, pad_cur;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                new_valid;
    result_t             new_res;
    logic                out_free;
    logic [DIM_W-1:0]    col_inc;
    logic                is_last;
    logic [7:0]          b;

    function automatic logic [DIM_W-1:0] size_fold(
        input logic [DIM_W-1:0] acc,
        input logic [1:0]       pos,
        input logic [7:0]       data
    );
        logic [15:0] v;
        v = {data, acc[7:0]};
        case (pos)
            2'd0:    size_fold = {5'd0, data};
            2'd1:    size_fold = (v[15:13] != 3'd0) ? SIZE_SAT : v[DIM_W-1:0];
            default: size_fold = (data != 8'd0) ? SIZE_SAT : acc;
        endcase
    endfunction

    assign out_free  = !out_valid_reg || res_ready;
    assign item_take = item_valid && out_free;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign b         = item.file_byte;

    always_comb begin
        phase_cur  = phase_reg;
        hcount_cur = hcount_reg;
        width_cur  = width_reg;
        height_cur = height_reg;
        column_cur = column_reg;
        row_cur    = row_reg;
        bip_cur    = bip_reg;
        held_cur   = held_reg;
        pad_cur    = pad_reg;
        if (item.first) begin
            phase_cur  = PH_HEADER;
            hcount_cur = '0;
            width_cur  = '0;
            height_cur = '0;
            column_cur = '0;
            row_cur    = '0;
            bip_cur    = '0;
            held_cur   = '0;
            pad_cur    = '0;
        end

        phase_next  = phase_cur;
        hcount_next = hcount_cur;
        width_next  = width_cur;
        height_next = height_cur;
        column_next = column_cur;
        row_next    = row_cur;
        bip_next    = bip_cur;
        held_next   = held_cur;
        pad_next    = pad_cur;
        new_valid   = 1'b0;
        new_res     = '0;
        col_inc     = {1'b0, column_cur} + 13'd1;
        is_last     = (col_inc == width_cur) && (row_cur == '0);

        case (phase_cur)
            PH_HEADER: begin
                hcount_next = hcount_cur + 6'd1;
                if ((hcount_cur == SIG_B_POS && b != CHAR_B) ||
                    (hcount_cur == SIG_M_POS && b != CHAR_M)) begin
                    new_valid     = 1'b1;
                    new_res.error = 1'b1;
                    phase_next    = PH_IDLE;
                end else begin
                    if (hcount_cur >= WIDTH_LO && hcount_cur <= WIDTH_HI) begin
                        width_next = size_fold(width_cur, 2'(hcount_cur - WIDTH_LO), b);
                    end
                    if (hcount_cur >= HEIGHT_LO && hcount_cur <= HEIGHT_HI) begin
                        height_next = size_fold(height_cur, 2'(hcount_cur - HEIGHT_LO), b);
                    end
                    if (hcount_cur == HDR_LAST) begin
                        if (width_cur == '0 || height_cur == '0 ||
                            width_cur > MAX_DIM || height_cur > MAX_DIM) begin
                            new_valid     = 1'b1;
                            new_res.error = 1'b1;
                            phase_next    = PH_IDLE;
                        end else begin
                            phase_next  = PH_PIXELS;
                            column_next = '0;
                            row_next    = COORD_W'(height_cur - 13'd1);
                            bip_next    = '0;
                            held_next   = '0;
                        end
                    end
                end
            end
            PH_PIXELS: begin
                if (bip_cur != 2'd2) begin
                    held_next = {held_cur[7:0], b};
                    bip_next  = bip_cur + 2'd1;
                end else begin
                    bip_next           = '0;
                    held_next          = '0;
                    new_valid          = 1'b1;
                    new_res.pixel_word = {ALPHA, held_cur, b};
                    new_res.column     = column_cur;
                    new_res.row        = row_cur;
                    new_res.last       = is_last;
                    column_next        = col_inc[COORD_W-1:0];
                    if (is_last) begin
                        phase_next = PH_IDLE;
                    end else if (col_inc >= width_cur) begin
                        column_next = '0;
                        pad_next    = width_cur[1:0];
                        if (row_cur != '0) begin
                            row_next = row_cur - 12'd1;
                        end
                        if (width_cur[1:0] != 2'd0) begin
                            phase_next = PH_PAD;
                        end
                    end
                end
            end
            PH_PAD: begin
                if (pad_cur != 2'd0) begin
                    pad_next = pad_cur - 2'd1;
                end
                if (pad_cur <= 2'd1) begin
                    phase_next = PH_PIXELS;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            column_reg <= '0;
            row_reg    <= '0;
            bip_reg    <= '0;
            held_reg   <= '0;
            pad_reg    <= '0;
        end else if (item_take) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            held_reg   <= held_next;
            pad_reg    <= pad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= item_valid && new_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && new_valid) begin
            out_reg <= new_res;
        end
    end

    a_pad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAD |-> pad_reg != 2'd0)
        else $error("padding phase with nothing left to skip");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && new_valid && new_res.last) |=> phase_reg == PH_IDLE)
        else $error("parser not idle after final pixel");

    a_bip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXELS |-> bip_reg != 2'd3)
        else $error("pixel byte count out of range");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXELS |-> {1'b0, column_reg} < width_reg)
        else $error("column beyond image width");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result word changed while stalled");

endmodule
`default_nettype wire
